@@ src/i2cwm_pkg.sv @@
// Package for the write-only I2C master bit sequencer.
// Holds command and register codes, reset values, sequencer phases and shared structs.
// No dependencies.
package i2cwm_pkg;

   localparam int unsigned ADDR_W  = 7;
   localparam int unsigned HOLD_W  = 8;
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned FUNC_W  = 2;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 8;

   // command codes
   localparam logic [FUNC_W-1:0] FUNC_START = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_DATA  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_STOP  = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SLAVE_ADDRESS   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RISE_HOLD       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HALF_CLOCK_HOLD = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_START_STOP_HOLD = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_IDLE_HOLD       = 3'd4;

   // register reset values
   localparam logic [ADDR_W-1:0] SLAVE_ADDRESS_RST   = 7'd60;
   localparam logic [HOLD_W-1:0] RISE_HOLD_RST       = 8'd0;
   localparam logic [HOLD_W-1:0] HALF_CLOCK_HOLD_RST = 8'd1;
   localparam logic [HOLD_W-1:0] START_STOP_HOLD_RST = 8'd1;
   localparam logic [HOLD_W-1:0] IDLE_HOLD_RST       = 8'd3;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_START_SDA,
      PH_START_SCL,
      PH_BIT,
      PH_STOP_SDA,
      PH_STOP_SCL,
      PH_STOP_IDLE
   } phase_type;

   typedef struct packed {
      logic [HOLD_W-1:0] rise;
      logic [HOLD_W-1:0] half_clock;
      logic [HOLD_W-1:0] start_stop;
      logic [HOLD_W-1:0] idle;
   } hold_cfg_type;

   typedef struct packed {
      logic              scl;
      logic              sda;
      logic [HOLD_W-1:0] hold;
      logic              last;
   } step_type;

endpackage

@@ src/i2cwm_if.sv @@
// Channel interfaces for the I2C master bit sequencer: command, line change, register write.
// Depends on i2cwm_pkg.
interface i2cwm_req_if import i2cwm_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [FUNC_W-1:0] func;
   logic [BYTE_W-1:0] data_byte;

   modport source (output valid, func, data_byte, input ready);
   modport sink   (input valid, func, data_byte, output ready);
endinterface

interface i2cwm_rsp_if import i2cwm_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              scl_level;
   logic              sda_level;
   logic [HOLD_W-1:0] hold_units;
   logic              last_phase;

   modport source (output valid, scl_level, sda_level, hold_units, last_phase, input ready);
   modport sink   (input valid, scl_level, sda_level, hold_units, last_phase, output ready);
endinterface

interface i2cwm_csr_if import i2cwm_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ src/i2cwm_seq.sv @@
// Phase sequencer: walks one command through its line changes and decodes each change.
// Depends on i2cwm_pkg.
module i2cwm_seq
   import i2cwm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  logic [FUNC_W-1:0] load_func,
   input  logic [BYTE_W-1:0] load_byte,
   input  logic              advance,
   input  logic              clock_line,
   input  logic              data_line,
   input  hold_cfg_type      holds,
   output logic              busy,
   output step_type          step
);

   localparam logic [1:0] STEP_SDA   = 2'd0;
   localparam logic [1:0] STEP_SCL_H = 2'd1;
   localparam logic [1:0] STEP_SCL_L = 2'd2;
   localparam logic [3:0] ACK_SLOT   = 4'd8;

   phase_type         phase_ff, phase_in;
   logic [3:0]        bit_cnt_ff, bit_cnt_in;
   logic [1:0]        step_cnt_ff, step_cnt_in;
   logic [BYTE_W-1:0] byte_ff, byte_in;
   logic              bit_value;

   assign busy = (phase_ff != PH_IDLE);

   // next state
   always_comb begin
      phase_in    = phase_ff;
      bit_cnt_in  = bit_cnt_ff;
      step_cnt_in = step_cnt_ff;
      byte_in     = byte_ff;
      if (load) begin
         byte_in     = load_byte;
         bit_cnt_in  = 4'd0;
         step_cnt_in = STEP_SDA;
         case (load_func)
            FUNC_START: phase_in = PH_START_SDA;
            FUNC_DATA:  phase_in = PH_BIT;
            FUNC_STOP:  phase_in = PH_STOP_SDA;
            default:    phase_in = PH_IDLE;
         endcase
      end else if (advance) begin
         case (phase_ff)
            PH_START_SDA: phase_in = PH_START_SCL;
            PH_START_SCL: phase_in = PH_BIT;
            PH_BIT: begin
               case (step_cnt_ff)
                  STEP_SDA:   step_cnt_in = STEP_SCL_H;
                  STEP_SCL_H: step_cnt_in = STEP_SCL_L;
                  default: begin
                     step_cnt_in = STEP_SDA;
                     if (bit_cnt_ff == ACK_SLOT) begin
                        phase_in = PH_IDLE;
                     end else begin
                        bit_cnt_in = bit_cnt_ff + 4'd1;
                     end
                  end
               endcase
            end
            PH_STOP_SDA:  phase_in = PH_STOP_SCL;
            PH_STOP_SCL:  phase_in = PH_STOP_IDLE;
            default:      phase_in = PH_IDLE;
         endcase
      end
   end

   // ack slot releases SDA; data bits go MSB first
   assign bit_value = bit_cnt_ff[3] ? 1'b1 : byte_ff[3'd7 - bit_cnt_ff[2:0]];

   // outputs
   always_comb begin
      step.scl  = clock_line;
      step.sda  = data_line;
      step.hold = holds.half_clock;
      step.last = 1'b0;
      case (phase_ff)
         PH_START_SDA: begin
            step.sda  = 1'b0;
            step.hold = holds.start_stop;
         end
         PH_START_SCL: begin
            step.scl  = 1'b0;
         end
         PH_BIT: begin
            case (step_cnt_ff)
               STEP_SDA: begin
                  step.sda  = bit_value;
                  step.hold = holds.rise;
               end
               STEP_SCL_H: step.scl = 1'b1;
               default: begin
                  step.scl  = 1'b0;
                  step.last = (bit_cnt_ff == ACK_SLOT);
               end
            endcase
         end
         PH_STOP_SDA: begin
            step.sda  = 1'b0;
            step.hold = holds.rise;
         end
         PH_STOP_SCL: begin
            step.scl  = 1'b1;
            step.hold = holds.start_stop;
         end
         PH_STOP_IDLE: begin
            step.sda  = 1'b1;
            step.hold = holds.idle;
            step.last = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
      bit_cnt_ff  <= bit_cnt_in;
      step_cnt_ff <= step_cnt_in;
      byte_ff     <= byte_in;
   end

endmodule

@@ src/i2c_write_master_bit_sequencer.sv @@
// Top level of the write-only I2C master bit sequencer.
// Depends on i2cwm_pkg, the channel interfaces and i2cwm_seq.
//
// Usage:
//   req_chan carries commands: func 0 = start and send address byte (write),
//   1 = send data_byte, 2 = stop; func 3 is taken and dropped without output.
//   rsp_chan carries one transaction per line change: SCL and SDA levels
//   (1 = released) and hold_units to keep them. last_phase marks the final
//   change of a command.
//   csr_chan writes the address and hold registers; it is always ready and
//   must only be used while no command is in flight.
//   A command yields 29 (start), 27 (data) or 3 (stop) line changes, one per
//   cycle while the receiver does not stall; the phase sequencer registers
//   the command, and its first change then enters the output register.
//   The phase sequencer sets that rate; the next command is taken in the cycle
//   its predecessor's last change enters the output register.
//   When the receiver stalls, the output register holds its transaction and
//   the sequencer pauses. Reset releases both lines, loads register defaults
//   (address 60, holds 0/1/1/3) and empties the pipeline.
module i2c_write_master_bit_sequencer
   import i2cwm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   i2cwm_req_if.sink   req_chan,
   i2cwm_rsp_if.source rsp_chan,
   i2cwm_csr_if.sink   csr_chan
);

   logic [ADDR_W-1:0] slave_address_ff;
   hold_cfg_type      holds_ff;
   logic              clock_line_ff, data_line_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   step_type          rsp_step_ff;

   logic              busy;
   step_type          step;
   logic              advance;
   logic              req_acc;
   logic              csr_acc;
   logic [BYTE_W-1:0] load_byte;

   assign advance = busy && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !busy || (advance && step.last);
   assign req_acc = req_chan.valid && req_chan.ready;
   assign load_byte = (req_chan.func == FUNC_START) ? {slave_address_ff, 1'b0}
                                                    : req_chan.data_byte;

   assign csr_chan.ready = 1'b1;
   assign csr_acc = csr_chan.valid && csr_chan.ready;

   i2cwm_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .load       (req_acc),
      .load_func  (req_chan.func),
      .load_byte  (load_byte),
      .advance    (advance),
      .clock_line (clock_line_ff),
      .data_line  (data_line_ff),
      .holds      (holds_ff),
      .busy       (busy),
      .step       (step)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slave_address_ff    <= SLAVE_ADDRESS_RST;
         holds_ff.rise       <= RISE_HOLD_RST;
         holds_ff.half_clock <= HALF_CLOCK_HOLD_RST;
         holds_ff.start_stop <= START_STOP_HOLD_RST;
         holds_ff.idle       <= IDLE_HOLD_RST;
         clock_line_ff       <= 1'b1;
         data_line_ff        <= 1'b1;
         rsp_valid_ff        <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            clock_line_ff <= step.scl;
            data_line_ff  <= step.sda;
         end
         if (csr_acc) begin
            case (csr_chan.index)
               CSR_SLAVE_ADDRESS:   slave_address_ff    <= csr_chan.data[ADDR_W-1:0];
               CSR_RISE_HOLD:       holds_ff.rise       <= csr_chan.data;
               CSR_HALF_CLOCK_HOLD: holds_ff.half_clock <= csr_chan.data;
               CSR_START_STOP_HOLD: holds_ff.start_stop <= csr_chan.data;
               CSR_IDLE_HOLD:       holds_ff.idle       <= csr_chan.data;
               default: ;
            endcase
         end
      end
      if (advance) begin
         rsp_step_ff <= step;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.scl_level  = rsp_step_ff.scl;
   assign rsp_chan.sda_level  = rsp_step_ff.sda;
   assign rsp_chan.hold_units = rsp_step_ff.hold;
   assign rsp_chan.last_phase = rsp_step_ff.last;

   // a new command only overlaps the final change of the previous one
   a_accept_only_at_end: assert property (@(posedge clock) disable iff (reset)
      req_acc |-> (!busy || (advance && step.last)))
      else $error("command taken while sequencer mid-command");

   // sequencer goes idle after the final change unless a command is loaded
   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      (advance && step.last && !req_acc) |=> !busy)
      else $error("sequencer still busy after last change");

   // tracked line levels always match the last issued transaction
   a_lines_track: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (clock_line_ff == rsp_step_ff.scl && data_line_ff == rsp_step_ff.sda))
      else $error("line state out of step with output register");

endmodule
